// ----- hdl/tnsl_pkg.sv -----
`default_nettype none

package tnsl_pkg;

  // Fixed field widths
  localparam int COORD_W     = 16;
  localparam int LABEL_W     = 3;
  localparam int KIND_W      = 2;
  localparam int GRID_W      = 9;
  localparam int CFG_INDEX_W = 1;

  // Fold unit: input bits consumed per cycle
  localparam int FOLD_BITS   = 4;
  localparam int FOLD_STEPS  = COORD_W / FOLD_BITS;
  localparam int FOLD_CNT_W  = $clog2(FOLD_STEPS);

  // Register reset values
  localparam logic [GRID_W-1:0]  GRID_RESET  = 9'd64;
  localparam logic [LABEL_W-1:0] LABEL_RESET = 3'd0;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_SIZE     = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_LABEL = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FOLD = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  // Fold unit control
  typedef struct packed {
    logic load;
    logic neg_x;
    logic neg_y;
  } fold_ctrl_t;

  // Distance pipeline status
  typedef struct packed {
    logic busy;
    logic valid;
  } dist_stat_t;

endpackage

`default_nettype wire

// ----- hdl/toroidal_nearest_seed_labeler.sv -----
`default_nettype none

// A clear or an unused kind is taken without entering the fold; an add or a query first passes
// the 4-bit per-cycle modulo fold, and a query on a nonempty store then feeds one seed per cycle
// through the shared distance pipeline.
// Throughput: one word at a time; busy stays high until the item is finished.
// Reset (rst, synchronous, active high): seed store empty, grid_size 64, default_label 0.
// Results are strobed for one cycle on done; the receiver cannot stall.
module toroidal_nearest_seed_labeler #(
  parameter int MAX_SEEDS = 16,
  parameter int MAX_GRID  = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [tnsl_pkg::KIND_W-1:0]          kind,
  input  logic signed [tnsl_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [tnsl_pkg::COORD_W-1:0]  coord_y,
  input  logic [tnsl_pkg::LABEL_W-1:0]         seed_label_in,
  output logic                                 done,
  output logic [tnsl_pkg::LABEL_W-1:0]         cell_label,
  input  logic                                 cfg_write,
  input  logic [tnsl_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tnsl_pkg::GRID_W-1:0]          cfg_data
);

  localparam int GRID_CAP = (MAX_GRID < 511) ? MAX_GRID : 511;
  localparam int CW       = $clog2(GRID_CAP);
  localparam int NW       = CW + 1;
  localparam int TW       = $clog2(MAX_SEEDS + 1);
  localparam int AW       = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int EW       = 2 * CW + tnsl_pkg::LABEL_W;
  localparam int DSW      = 2 * (CW + 2) + 1;

  tnsl_pkg::state_t               state;
  tnsl_pkg::state_t               state_next;
  logic [tnsl_pkg::GRID_W-1:0]    grid_size;
  logic [tnsl_pkg::LABEL_W-1:0]   default_label;
  logic [tnsl_pkg::GRID_W-1:0]    grid_clamp;
  logic [NW-1:0]                  n_eff;
  logic [NW-1:0]                  n_reg;
  logic [tnsl_pkg::KIND_W-1:0]    kind_reg;
  logic [tnsl_pkg::LABEL_W-1:0]   label_reg;
  logic [TW-1:0]                  seed_total;
  logic [TW-1:0]                  cnt;
  logic [CW-1:0]                  qx;
  logic [CW-1:0]                  qy;
  logic                           rd_valid;
  logic                           found;
  logic [DSW-1:0]                 best_dist;
  logic [tnsl_pkg::LABEL_W-1:0]   best_label;
  logic                           accept;
  logic                           issue;
  logic                           scan_end;
  logic                           store_we;
  logic [tnsl_pkg::COORD_W-1:0]   cx_u;
  logic [tnsl_pkg::COORD_W-1:0]   cy_u;
  logic [tnsl_pkg::COORD_W-1:0]   mag_x;
  logic [tnsl_pkg::COORD_W-1:0]   mag_y;
  tnsl_pkg::fold_ctrl_t           fold_ctrl;
  logic                           fold_done;
  logic [CW-1:0]                  fold_x;
  logic [CW-1:0]                  fold_y;
  logic [EW-1:0]                  rd_entry;
  tnsl_pkg::dist_stat_t           dstat;
  logic [DSW-1:0]                 dist_sum;
  logic [tnsl_pkg::LABEL_W-1:0]   dist_label;

  // Handshake
  assign busy   = (state != tnsl_pkg::ST_IDLE);
  assign accept = start && !busy;

  // Effective grid size: 0 acts as 1, clamp to the largest grid
  always_comb begin
    if (grid_size == '0) begin
      grid_clamp = tnsl_pkg::GRID_W'(1);
    end else if (grid_size > tnsl_pkg::GRID_W'(GRID_CAP)) begin
      grid_clamp = tnsl_pkg::GRID_W'(GRID_CAP);
    end else begin
      grid_clamp = grid_size;
    end
  end
  assign n_eff = NW'(grid_clamp);

  // Sign and magnitude for the fold unit
  assign cx_u  = unsigned'(coord_x);
  assign cy_u  = unsigned'(coord_y);
  assign mag_x = cx_u[tnsl_pkg::COORD_W-1] ? (~cx_u + 1'b1) : cx_u;
  assign mag_y = cy_u[tnsl_pkg::COORD_W-1] ? (~cy_u + 1'b1) : cy_u;

  assign fold_ctrl.load  = accept && (kind inside {tnsl_pkg::KIND_ADD, tnsl_pkg::KIND_QUERY});
  assign fold_ctrl.neg_x = cx_u[tnsl_pkg::COORD_W-1];
  assign fold_ctrl.neg_y = cy_u[tnsl_pkg::COORD_W-1];

  tnsl_fold #(
    .CW (CW)
  ) u_fold (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (fold_ctrl),
    .mag_x  (mag_x),
    .mag_y  (mag_y),
    .n      (n_reg),
    .done   (fold_done),
    .fold_x (fold_x),
    .fold_y (fold_y)
  );

  // Seed store
  assign store_we = (state == tnsl_pkg::ST_FOLD) && fold_done &&
                    (kind_reg == tnsl_pkg::KIND_ADD) && (seed_total < TW'(MAX_SEEDS));

  tnsl_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_SEEDS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (seed_total[AW-1:0]),
    .wdata ({fold_x, fold_y, label_reg}),
    .raddr (cnt[AW-1:0]),
    .rdata (rd_entry)
  );

  tnsl_dist #(
    .CW (CW)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .qx        (qx),
    .qy        (qy),
    .sx        (rd_entry[EW-1 -: CW]),
    .sy        (rd_entry[tnsl_pkg::LABEL_W +: CW]),
    .label_in  (rd_entry[tnsl_pkg::LABEL_W-1:0]),
    .n         (n_reg),
    .stat      (dstat),
    .dist_sum  (dist_sum),
    .label_out (dist_label)
  );

  // Scan control
  assign issue    = (state == tnsl_pkg::ST_SCAN) && (cnt < seed_total);
  assign scan_end = (state == tnsl_pkg::ST_SCAN) && !issue && !rd_valid && !dstat.busy;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tnsl_pkg::ST_IDLE: begin
        if (fold_ctrl.load) begin
          state_next = tnsl_pkg::ST_FOLD;
        end
      end
      tnsl_pkg::ST_FOLD: begin
        if (fold_done) begin
          if (kind_reg == tnsl_pkg::KIND_QUERY && seed_total != '0) begin
            state_next = tnsl_pkg::ST_SCAN;
          end else begin
            state_next = tnsl_pkg::ST_IDLE;
          end
        end
      end
      tnsl_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = tnsl_pkg::ST_IDLE;
        end
      end
      default: state_next = tnsl_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tnsl_pkg::ST_IDLE;
      grid_size     <= tnsl_pkg::GRID_RESET;
      default_label <= tnsl_pkg::LABEL_RESET;
      seed_total    <= '0;
      rd_valid      <= 1'b0;
      done          <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      done     <= 1'b0;

      // config writes
      if (cfg_write) begin
        case (cfg_index)
          tnsl_pkg::REG_GRID_SIZE:     grid_size     <= cfg_data;
          tnsl_pkg::REG_DEFAULT_LABEL: default_label <= cfg_data[tnsl_pkg::LABEL_W-1:0];
          default: ;
        endcase
      end

      if (accept && kind == tnsl_pkg::KIND_CLEAR) begin
        seed_total <= '0;
      end
      if (store_we) begin
        seed_total <= seed_total + 1'b1;
      end

      // query with an empty store, or end of scan
      if (state == tnsl_pkg::ST_FOLD && fold_done && kind_reg == tnsl_pkg::KIND_QUERY &&
          seed_total == '0) begin
        done <= 1'b1;
      end
      if (scan_end) begin
        done <= 1'b1;
      end
    end
  end

  // Item payload, scan counter and running minimum
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_reg  <= kind;
      label_reg <= seed_label_in;
      n_reg     <= n_eff;
    end
    if (state == tnsl_pkg::ST_FOLD && fold_done) begin
      qx    <= fold_x;
      qy    <= fold_y;
      cnt   <= '0;
      found <= 1'b0;
    end else if (issue) begin
      cnt <= cnt + 1'b1;
    end
    // first strictly smaller distance wins
    if (dstat.valid && (!found || dist_sum < best_dist)) begin
      found      <= 1'b1;
      best_dist  <= dist_sum;
      best_label <= dist_label;
    end
    if (state == tnsl_pkg::ST_FOLD && fold_done) begin
      cell_label <= default_label;
    end else if (scan_end) begin
      cell_label <= best_label;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tnsl_ram.sv -----
`default_nettype none

module tnsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/tnsl_fold.sv -----
`default_nettype none

module tnsl_fold #(
  parameter int CW = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tnsl_pkg::fold_ctrl_t           ctrl,
  input  logic [tnsl_pkg::COORD_W-1:0]   mag_x,
  input  logic [tnsl_pkg::COORD_W-1:0]   mag_y,
  input  logic [CW:0]                    n,
  output logic                           done,
  output logic [CW-1:0]                  fold_x,
  output logic [CW-1:0]                  fold_y
);

  localparam int NW = CW + 1;

  logic [tnsl_pkg::COORD_W-1:0]   sh_x;
  logic [tnsl_pkg::COORD_W-1:0]   sh_y;
  logic [NW-1:0]                  rem_x;
  logic [NW-1:0]                  rem_y;
  logic                           neg_x;
  logic                           neg_y;
  logic [tnsl_pkg::FOLD_CNT_W-1:0] step_cnt;
  logic                           running;

  // Restoring remainder over a few bits: shift in a bit, subtract n if it fits
  function automatic logic [NW-1:0] mod_steps(
    input logic [NW-1:0]                  r_in,
    input logic [tnsl_pkg::FOLD_BITS-1:0] bits,
    input logic [NW-1:0]                  m
  );
    logic [NW:0]   t;
    logic [NW-1:0] r;
    r = r_in;
    for (int i = tnsl_pkg::FOLD_BITS - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, m}) begin
        t = t - {1'b0, m};
      end
      r = t[NW-1:0];
    end
    return r;
  endfunction

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.load) begin
        running  <= 1'b1;
        step_cnt <= '0;
      end else if (running) begin
        step_cnt <= step_cnt + 1'b1;
        if (step_cnt == tnsl_pkg::FOLD_CNT_W'(tnsl_pkg::FOLD_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Both axes, MSB first
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sh_x  <= mag_x;
      sh_y  <= mag_y;
      rem_x <= '0;
      rem_y <= '0;
      neg_x <= ctrl.neg_x;
      neg_y <= ctrl.neg_y;
    end else if (running) begin
      rem_x <= mod_steps(rem_x, sh_x[tnsl_pkg::COORD_W-1 -: tnsl_pkg::FOLD_BITS], n);
      rem_y <= mod_steps(rem_y, sh_y[tnsl_pkg::COORD_W-1 -: tnsl_pkg::FOLD_BITS], n);
      sh_x  <= sh_x << tnsl_pkg::FOLD_BITS;
      sh_y  <= sh_y << tnsl_pkg::FOLD_BITS;
    end
  end

  // Floor modulo: a negative value with a nonzero remainder maps to n - r
  assign fold_x = (neg_x && rem_x != '0) ? CW'(n - rem_x) : CW'(rem_x);
  assign fold_y = (neg_y && rem_y != '0) ? CW'(n - rem_y) : CW'(rem_y);

endmodule

`default_nettype wire

// ----- hdl/tnsl_dist.sv -----
`default_nettype none

module tnsl_dist #(
  parameter int CW = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [CW-1:0]                  qx,
  input  logic [CW-1:0]                  qy,
  input  logic [CW-1:0]                  sx,
  input  logic [CW-1:0]                  sy,
  input  logic [tnsl_pkg::LABEL_W-1:0]   label_in,
  input  logic [CW:0]                    n,
  output tnsl_pkg::dist_stat_t           stat,
  output logic [2*(CW+2):0]              dist_sum,
  output logic [tnsl_pkg::LABEL_W-1:0]   label_out
);

  localparam int NW = CW + 1;
  localparam int DW = CW + 2;
  localparam int SW = 2 * DW;

  logic signed [DW-1:0]          wx;
  logic signed [DW-1:0]          wy;
  logic signed [SW-1:0]          px;
  logic signed [SW-1:0]          py;
  logic [SW-1:0]                 sq_x;
  logic [SW-1:0]                 sq_y;
  logic [tnsl_pkg::LABEL_W-1:0]  label_s1;
  logic                          valid_s1;
  logic                          valid_s2;

  // Per-axis difference with a single toroidal wrap step
  function automatic logic signed [DW-1:0] wrap_diff(
    input logic [CW-1:0] a,
    input logic [CW-1:0] b,
    input logic [NW-1:0] m
  );
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] half;
    logic signed [DW-1:0] mm;
    d    = signed'({2'b00, a}) - signed'({2'b00, b});
    half = signed'({1'b0, m >> 1});
    mm   = signed'({1'b0, m});
    if (d > half) begin
      d = d - mm;
    end else if (d < -half) begin
      d = d + mm;
    end
    return d;
  endfunction

  assign wx = wrap_diff(qx, sx, n);
  assign wy = wrap_diff(qy, sy, n);
  assign px = wx * wx;
  assign py = wy * wy;

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1 <= 1'b0;
      valid_s2 <= 1'b0;
    end else begin
      valid_s1 <= in_valid;
      valid_s2 <= valid_s1;
    end
  end

  // Square, then sum
  always_ff @(posedge clk) begin
    sq_x      <= unsigned'(px);
    sq_y      <= unsigned'(py);
    label_s1  <= label_in;
    dist_sum  <= {1'b0, sq_x} + {1'b0, sq_y};
    label_out <= label_s1;
  end

  assign stat.busy  = valid_s1 | valid_s2;
  assign stat.valid = valid_s2;

endmodule

`default_nettype wire

// ----- dv/nearest_seed_checker.sv -----
`default_nettype none

module nearest_seed_checker
  import tnsl_pkg::*;
#(
  parameter int MAX_SEEDS = 16,
  parameter int MAX_GRID  = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [KIND_W-1:0]          kind,
  input  logic signed [COORD_W-1:0]  coord_x,
  input  logic signed [COORD_W-1:0]  coord_y,
  input  logic [LABEL_W-1:0]         seed_label_in,
  input  logic                       done,
  input  logic [LABEL_W-1:0]         cell_label,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [GRID_W-1:0]          cfg_data,
  output int                         outstanding,
  output int                         errors
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow registers and seed store
  logic [GRID_W-1:0]  grid_reg;
  logic [LABEL_W-1:0] label_reg;
  int                 seed_x [MAX_SEEDS];
  int                 seed_y [MAX_SEEDS];
  logic [LABEL_W-1:0] seed_lab [MAX_SEEDS];
  int                 seed_count;

  // Labels owed by queries already taken, oldest first
  logic [LABEL_W-1:0] expected_labels [$];

  int                 side;
  int                 cell_x;
  int                 cell_y;
  logic [LABEL_W-1:0] want;

  initial begin
    errors = 0;
    outstanding = 0;
  end

  // One line per mismatch, each one counted
  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  // Grid side in force: zero acts as one, oversize is clamped
  function automatic int grid_side(logic [GRID_W-1:0] g);
    if (g == 0) return 1;
    if (g > MAX_GRID) return MAX_GRID;
    return int'(g);
  endfunction

  // Floor modulo into [0, n)
  function automatic int fold_coord(int v, int n);
    int r;
    r = v % n;
    if (r < 0) r += n;
    return r;
  endfunction

  // Single toroidal wrap step of a per-axis difference
  function automatic int wrap_axis(int d, int n);
    if (d > n / 2) return d - n;
    if (d < -(n / 2)) return d + n;
    return d;
  endfunction

  // Nearest stored seed; earliest seed keeps a tie
  function automatic logic [LABEL_W-1:0] nearest_label(int cx, int cy, int n);
    int dx;
    int dy;
    int sum_sq;
    int best;
    logic [LABEL_W-1:0] winner;
    winner = label_reg;
    best = -1;
    for (int k = 0; k < seed_count; k++) begin
      dx = wrap_axis(cx - seed_x[k], n);
      dy = wrap_axis(cy - seed_y[k], n);
      sum_sq = dx * dx + dy * dy;
      if (best < 0 || sum_sq < best) begin
        best = sum_sq;
        winner = seed_lab[k];
      end
    end
    return winner;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      grid_reg = GRID_RESET;
      label_reg = LABEL_RESET;
      seed_count = 0;
      expected_labels.delete();
    end else begin
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_GRID_SIZE:     grid_reg = cfg_data;
          REG_DEFAULT_LABEL: label_reg = cfg_data[LABEL_W-1:0];
          default: ;
        endcase
      end

      // result words
      if (done) begin
        if (expected_labels.size() == 0) begin
          report_mismatch($sformatf("label %0d with no query pending", cell_label));
        end else begin
          want = expected_labels.pop_front();
          if (cell_label !== want) begin
            report_mismatch($sformatf("cell_label %0d, expected %0d", cell_label, want));
          end
        end
      end

      // accepted items
      if (start && !busy) begin
        side = grid_side(grid_reg);
        cell_x = fold_coord(int'(coord_x), side);
        cell_y = fold_coord(int'(coord_y), side);
        case (kind)
          KIND_CLEAR: seed_count = 0;
          KIND_ADD: begin
            if (seed_count < MAX_SEEDS) begin
              seed_x[seed_count] = cell_x;
              seed_y[seed_count] = cell_y;
              seed_lab[seed_count] = seed_label_in;
              seed_count++;
            end
          end
          KIND_QUERY: expected_labels.push_back(nearest_label(cell_x, cell_y, side));
          default: ;
        endcase
      end
    end
    outstanding <= expected_labels.size();
  end

endmodule

`default_nettype wire

// ----- dv/toroidal_nearest_seed_labeler_test.sv -----
`default_nettype none

module toroidal_nearest_seed_labeler_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tnsl_pkg::*;

  localparam int MAX_SEEDS     = 16;
  localparam int MAX_GRID      = 256;
  localparam int TARGET_ITEMS  = 1120;
  localparam int SETTLE_CYCLES = 32;
  localparam int STALL_LIMIT   = 2000;

  // kind code the block ignores
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic [KIND_W-1:0]          kind = KIND_CLEAR;
  logic signed [COORD_W-1:0]  coord_x = '0;
  logic signed [COORD_W-1:0]  coord_y = '0;
  logic [LABEL_W-1:0]         seed_label_in = '0;
  logic                       done;
  logic [LABEL_W-1:0]         cell_label;
  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]     cfg_index = REG_GRID_SIZE;
  logic [GRID_W-1:0]          cfg_data = '0;

  int  outstanding;
  int  mismatch_total;
  int  items_sent = 0;
  int  idle_cycles = 0;
  bit  no_gaps = 1'b0;

  toroidal_nearest_seed_labeler #(
    .MAX_SEEDS (MAX_SEEDS),
    .MAX_GRID  (MAX_GRID)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .seed_label_in (seed_label_in),
    .done          (done),
    .cell_label    (cell_label),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  nearest_seed_checker #(
    .MAX_SEEDS (MAX_SEEDS),
    .MAX_GRID  (MAX_GRID)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .seed_label_in (seed_label_in),
    .done          (done),
    .cell_label    (cell_label),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .outstanding   (outstanding),
    .errors        (mismatch_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: too long with no word moving in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("toroidal_nearest_seed_labeler test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Coordinates biased toward the grid, its negative images and the extremes
  function automatic logic [COORD_W-1:0] pick_coord(int n);
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return COORD_W'($urandom());
    if (r < 75) return COORD_W'($urandom_range(0, n - 1));
    if (r < 90) return COORD_W'(-int'($urandom_range(1, 3 * n)));
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      3: return '1;
      4: return COORD_W'(n);
      5: return COORD_W'(-n);
      6: return COORD_W'(n / 2);
      default: return COORD_W'(-(n / 2));
    endcase
  endfunction

  // Present one word and hold it until the block takes it
  task automatic send_word(input logic [KIND_W-1:0] k, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic [LABEL_W-1:0] lab);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    coord_x <= x;
    coord_y <= y;
    seed_label_in <= lab;
    do @(posedge clk); while (busy);
    if (k != KIND_UNUSED) items_sent++;
  endtask

  // Occasional word of the unused kind with random fields
  task automatic maybe_noise();
    if ($urandom_range(0, 99) < 3) begin
      send_word(KIND_UNUSED, COORD_W'($urandom()), COORD_W'($urandom()), LABEL_W'($urandom()));
    end
  endtask

  // Drop start, let every query answer, then let a trailing add or clear finish
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers, back to back; upper data bits of the label write are junk
  task automatic write_regs(input int grid, input int dflt);
    cfg_write <= 1'b1;
    cfg_index <= REG_GRID_SIZE;
    cfg_data <= GRID_W'(grid);
    @(posedge clk);
    cfg_index <= REG_DEFAULT_LABEL;
    cfg_data <= {(GRID_W - LABEL_W)'($urandom()), LABEL_W'(dflt)};
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int grid_plan [12];
    int phase;
    int grid;
    int side;
    int nseq;
    int nadd;
    int nquery;
    int r;

    grid_plan = '{0, 1, 2, 3, 5, 16, 63, 64, 255, 256, 257, 511};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: grid 64, default label 0 from reset
    send_word(KIND_QUERY, 16'd0, 16'd0, '0);              // empty store
    send_word(KIND_UNUSED, '1, '1, '1);
    send_word(KIND_CLEAR, '1, '1, '1);
    send_word(KIND_ADD, 16'h8000, 16'h8000, 3'd7);        // folds to (0,0)
    send_word(KIND_ADD, 16'h7FFF, 16'h7FFF, 3'd0);        // folds to (63,63)
    send_word(KIND_ADD, 16'd0, 16'd0, 3'd5);              // same spot, later
    send_word(KIND_QUERY, 16'd0, 16'd0, '1);              // tie, earliest wins
    send_word(KIND_QUERY, 16'hFFFF, 16'hFFFF, '0);
    send_word(KIND_QUERY, 16'd32, 16'd32, '0);            // exactly half a grid
    send_word(KIND_QUERY, 16'd32, 16'd0, '0);
    send_word(KIND_QUERY, 16'h8000, 16'h7FFF, '0);
    send_word(KIND_QUERY, 16'h7FFF, 16'h8000, '0);
    send_word(KIND_ADD, -16'sd33, 16'd95, 3'd3);
    send_word(KIND_QUERY, 16'd31, -16'sd33, '0);
    send_word(KIND_QUERY, -16'sd32, 16'd32, '0);
    send_word(KIND_QUERY, 16'd33, 16'd31, '0);
    send_word(KIND_CLEAR, '0, '0, '0);
    send_word(KIND_QUERY, 16'd5, 16'd5, '0);              // empty again
    wait_idle();

    // Random phases, each under its own register setting
    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      if (phase < 12) begin
        grid = grid_plan[phase];
      end else if ($urandom_range(0, 99) < 70) begin
        grid = $urandom_range(1, 64);
      end else begin
        grid = $urandom_range(0, 511);
      end
      side = (grid == 0) ? 1 : ((grid > MAX_GRID) ? MAX_GRID : grid);
      write_regs(grid, (phase * 5) % 8);
      no_gaps = ($urandom_range(0, 3) == 0);

      nseq = $urandom_range(3, 5);
      for (int s = 0; s < nseq; s++) begin
        // seeds left over from an earlier grid are kept now and then
        if (s > 0 || $urandom_range(0, 1) == 1) begin
          send_word(KIND_CLEAR, COORD_W'($urandom()), COORD_W'($urandom()),
                    LABEL_W'($urandom()));
        end
        r = $urandom_range(0, 99);
        if (r < 8) nadd = 0;
        else if (r < 88) nadd = $urandom_range(1, MAX_SEEDS);
        else nadd = $urandom_range(MAX_SEEDS + 1, MAX_SEEDS + 6);
        for (int a = 0; a < nadd; a++) begin
          maybe_noise();
          if ($urandom_range(0, 9) == 0) begin
            send_word(KIND_QUERY, pick_coord(side), pick_coord(side), LABEL_W'($urandom()));
          end
          send_word(KIND_ADD, pick_coord(side), pick_coord(side), LABEL_W'($urandom()));
        end
        nquery = $urandom_range(2, 10);
        for (int q = 0; q < nquery; q++) begin
          maybe_noise();
          send_word(KIND_QUERY, pick_coord(side), pick_coord(side), LABEL_W'($urandom()));
        end
      end
      wait_idle();
      phase++;
    end

    if (mismatch_total == 0) begin
      $display("toroidal_nearest_seed_labeler test passed");
    end else begin
      $display("toroidal_nearest_seed_labeler test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
